// ===== src/wfps_pkg.sv =====
package wfps_pkg;

  // CORDIC sizing
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN = 24;
  localparam int IDX_W = 5;
  localparam int XY_W = 36;
  localparam int Z_W = 28;

  // Shared multiplier: signed A times signed B
  localparam int MA_W = 41;
  localparam int MB_W = 25;
  localparam int MP_W = 66;

  // Datapath word sizes
  localparam int PACC_W = 50;
  localparam int PROJ_W = 20;
  localparam int ERR_W = 24;
  localparam int INTEG_W = 48;
  localparam int SUM_W = 64;

  // Iterative divider
  localparam int DIV_W = 64;
  localparam int DEN_W = 28;
  localparam int DIV_BPC = 2;

  // Division by 62500: a shift by two, then radix 2^16 digits divided by 15625
  // through a reciprocal that is exact for every 30-bit partial dividend.
  localparam int CDIV_DIG_W = 16;
  localparam int CDIV_R_W = 14;
  localparam int CDIV_V_W = 30;
  localparam int CDIV_P_W = 61;
  localparam int CDIV_SHIFT = 44;
  localparam logic [CDIV_R_W-1:0] CDIV_D = 14'd15625;
  localparam logic [30:0] CDIV_RECIP = 31'd1125899907;

  // APB register window
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [15:0] FAR_RANGE = 16'd25600;
  localparam logic signed [XY_W-1:0] KINV_Q30 = 36'sd652032875;
  localparam logic [MB_W-1:0] US_PER_S = 25'd1000000;

  // Speed tiers
  localparam logic [2:0] SPEED_SLOW = 3'd2;
  localparam logic [2:0] SPEED_MID = 3'd3;
  localparam logic [2:0] SPEED_FAST = 3'd5;
  localparam logic [16:0] MAG_SLOW = 17'd1430;
  localparam logic [16:0] MAG_MID = 17'd715;

  typedef struct packed {
    logic [15:0] ray_a_range;
    logic        ray_a_valid;
    logic [15:0] ray_b_range;
    logic        ray_b_valid;
    logic [19:0] elapsed_us;
  } scan_t;

  typedef struct packed {
    logic signed [15:0] wheel_angle;
    logic [2:0]         speed_mps;
    logic signed [15:0] projected_distance;
  } steer_t;

  typedef struct packed {
    logic [23:0] gain_p;
    logic [23:0] gain_d;
    logic [23:0] gain_i;
    logic [15:0] target_distance;
    logic [15:0] lookahead_distance;
    logic [15:0] cos_separation;
    logic [15:0] sin_separation;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_D    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_TARGET    = 3'd3,
    REG_LOOKAHEAD = 3'd4,
    REG_COS_SEP   = 3'd5,
    REG_SIN_SEP   = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    MUL_NONE    = 4'd0,
    MUL_A_SIN   = 4'd1,
    MUL_A_COS   = 4'd2,
    MUL_B_X     = 4'd3,
    MUL_LA_Y    = 4'd4,
    MUL_LAST_DT = 4'd5,
    MUL_P_E     = 4'd6,
    MUL_I_INT   = 4'd7,
    MUL_DIFF_US = 4'd8,
    MUL_D_PROD  = 4'd9
  } mul_op_t;

  typedef struct packed {
    mul_op_t          mul_op;
    logic             load_in;
    logic             x_from_prod;
    logic             y_init;
    logic             vec_step;
    logic             rot_init;
    logic             rot_step;
    logic             pacc_load;
    logic             proj_load;
    logic             err_load;
    logic             integ_load;
    logic             sum_load;
    logic             div_start;
    logic             div_sel_d;
    logic             sum_add;
    logic             commit;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic dt_zero;
  } dp_sts_t;

  // Arctangent of 2^-i in units of 2^-24 rad.
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [IDX_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/wfps_div.sv =====
module wfps_div
  import wfps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [DIV_W-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic             done
);

  localparam int STEPS = DIV_W / DIV_BPC;
  localparam int CNT_W = $clog2(STEPS);

  logic [DIV_W-1:0] q;
  logic [DEN_W-1:0] r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DIV_W-1:0] q_w;
  logic [DEN_W-1:0] r_w;

  // Restoring division, DIV_BPC quotient bits per cycle.
  always_comb begin
    logic [DEN_W:0] t;
    q_w = q;
    r_w = r;
    for (int k = 0; k < DIV_BPC; k++) begin
      t = {r_w, q_w[DIV_W-1]};
      q_w = {q_w[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t = t - {1'b0, den_r};
        q_w[0] = 1'b1;
      end
      r_w = t[DEN_W-1:0];
    end
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      q     <= num;
      r     <= '0;
      den_r <= den;
    end else if (busy) begin
      q <= q_w;
      r <= r_w;
    end
  end

  assign quo = q;
  assign rem = r;

endmodule

// Division by 62500 in four radix 2^16 digits; each digit has an estimate phase and a remainder phase.
module wfps_cdiv
  import wfps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  output logic [DIV_W-1:0] quo,
  output logic             rem_nz,
  output logic             done
);

  localparam int DIGITS = DIV_W / CDIV_DIG_W;
  localparam int CNT_W = $clog2(DIGITS);

  logic [DIV_W-1:0]      m;
  logic [DIV_W-1:0]      q;
  logic [CDIV_R_W-1:0]   r;
  logic [CDIV_DIG_W-1:0] qd;
  logic                  low_nz;
  logic [CNT_W-1:0]      cnt;
  logic                  phase;
  logic                  busy;
  logic [CDIV_V_W-1:0]   v;
  logic [CDIV_P_W-1:0]   qprod;
  logic [CDIV_V_W-1:0]   rfull;

  // Partial dividend: running remainder and the next digit of the dividend.
  assign v     = {r, m[DIV_W-1 -: CDIV_DIG_W]};
  assign qprod = CDIV_P_W'(v) * CDIV_P_W'(CDIV_RECIP);
  assign rfull = v - CDIV_V_W'(qd) * CDIV_V_W'(CDIV_D);

  // Digit sequencing: estimate a quotient digit, then take the remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        phase <= 1'b0;
      end else if (busy) begin
        phase <= !phase;
        if (phase) begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIGITS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  // Dividend, quotient and remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      m      <= {2'b00, num[DIV_W-1:2]};
      q      <= '0;
      r      <= '0;
      low_nz <= (num[1:0] != 2'b00);
    end else if (busy) begin
      if (!phase) begin
        qd <= qprod[CDIV_SHIFT +: CDIV_DIG_W];
      end else begin
        r <= rfull[CDIV_R_W-1:0];
        q <= {q[DIV_W-CDIV_DIG_W-1:0], qd};
        m <= {m[DIV_W-CDIV_DIG_W-1:0], {CDIV_DIG_W{1'b0}}};
      end
    end
  end

  assign quo    = q;
  assign rem_nz = low_nz || (r != '0);

endmodule

// ===== src/wfps_cfg.sv =====
module wfps_cfg
  import wfps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p             <= 24'd1048576;
      cfg.gain_d             <= 24'd1049;
      cfg.gain_i             <= 24'd5243;
      cfg.target_distance    <= 16'd256;
      cfg.lookahead_distance <= 16'd256;
      cfg.cos_separation     <= 16'd23170;
      cfg.sin_separation     <= 16'd23170;
    end else if (wr) begin
      case (idx)
        REG_GAIN_P:    cfg.gain_p             <= pwdata[23:0];
        REG_GAIN_D:    cfg.gain_d             <= pwdata[23:0];
        REG_GAIN_I:    cfg.gain_i             <= pwdata[23:0];
        REG_TARGET:    cfg.target_distance    <= pwdata[15:0];
        REG_LOOKAHEAD: cfg.lookahead_distance <= pwdata[15:0];
        REG_COS_SEP:   cfg.cos_separation     <= pwdata[15:0];
        REG_SIN_SEP:   cfg.sin_separation     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back.
  always_comb begin
    case (idx)
      REG_GAIN_P:    prdata = DATA_W'(cfg.gain_p);
      REG_GAIN_D:    prdata = DATA_W'(cfg.gain_d);
      REG_GAIN_I:    prdata = DATA_W'(cfg.gain_i);
      REG_TARGET:    prdata = DATA_W'(cfg.target_distance);
      REG_LOOKAHEAD: prdata = DATA_W'(cfg.lookahead_distance);
      REG_COS_SEP:   prdata = DATA_W'(cfg.cos_separation);
      REG_SIN_SEP:   prdata = DATA_W'(cfg.sin_separation);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== src/wfps_dp.sv =====
module wfps_dp
  import wfps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  scan_t   scan,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output steer_t  result
);

  logic [15:0]               a_r;
  logic [15:0]               b_r;
  logic [19:0]               dt_r;
  logic signed [XY_W-1:0]    x;
  logic signed [XY_W-1:0]    y;
  logic signed [Z_W-1:0]     z;
  logic signed [MP_W-1:0]    prod;
  logic signed [PACC_W-1:0]  pacc;
  logic signed [PROJ_W-1:0]  proj;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   last_err;
  logic signed [INTEG_W-1:0] integ;
  logic signed [SUM_W-1:0]   sum;
  logic                      div_neg;
  logic                      div_is_d;

  logic signed [MA_W-1:0]    ma;
  logic signed [MB_W-1:0]    mb;
  logic signed [ERR_W:0]     diff;
  logic signed [INTEG_W-1:0] integ_sh;
  logic signed [XY_W-1:0]    xs;
  logic signed [XY_W-1:0]    ys;
  logic signed [Z_W-1:0]     at;
  logic signed [PACC_W-1:0]  psum;
  logic signed [PACC_W-1:0]  isum;
  logic signed [INTEG_W-1:0] integ_next;
  logic signed [MP_W-1:0]    dmag;
  logic [DEN_W-1:0]          den;
  logic [DIV_W-1:0]          quo_d;
  logic [DEN_W-1:0]          rem_d;
  logic                      done_d;
  logic [DIV_W-1:0]          quo_i;
  logic                      rem_i_nz;
  logic                      done_i;
  logic [DIV_W-1:0]          quo;
  logic                      rem_nz;
  logic                      div_done;
  logic signed [SUM_W-1:0]   qs;
  logic signed [SUM_W:0]     tsum;
  logic signed [SUM_W:0]     tsh;
  logic signed [15:0]        steer_sat;
  logic [16:0]               mag;
  logic [2:0]                speed;
  logic signed [15:0]        proj_sat;

  assign diff     = (ERR_W+1)'(err) - (ERR_W+1)'(last_err);
  assign integ_sh = integ >>> 12;

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_op)
      MUL_A_SIN: begin
        ma = MA_W'(a_r);
        mb = MB_W'(cfg.sin_separation);
      end
      MUL_A_COS: begin
        ma = MA_W'(a_r);
        mb = MB_W'(cfg.cos_separation);
      end
      MUL_B_X: begin
        ma = MA_W'(x);
        mb = MB_W'(b_r);
      end
      MUL_LA_Y: begin
        ma = MA_W'(y);
        mb = MB_W'(cfg.lookahead_distance);
      end
      MUL_LAST_DT: begin
        ma = MA_W'(last_err);
        mb = MB_W'(dt_r);
      end
      MUL_P_E: begin
        ma = MA_W'(err);
        mb = MB_W'(cfg.gain_p);
      end
      MUL_I_INT: begin
        ma = MA_W'(integ_sh);
        mb = MB_W'(cfg.gain_i);
      end
      MUL_DIFF_US: begin
        ma = MA_W'(diff);
        mb = US_PER_S;
      end
      MUL_D_PROD: begin
        ma = prod[MA_W-1:0];
        mb = MB_W'(cfg.gain_d);
      end
      default: ;
    endcase
  end

  // CORDIC shifts and table entry for this step.
  assign xs = x >>> cmd.idx;
  assign ys = y >>> cmd.idx;
  assign at = atan_lut(cmd.idx);

  // Projection sum rounded half up to Q.8.
  assign psum = pacc + PACC_W'(prod) + PACC_W'(64'sd536870912);

  // Saturating integral update.
  always_comb begin
    isum = PACC_W'(integ) + PACC_W'(prod);
    if (isum[PACC_W-1:INTEG_W-1] == '0 || isum[PACC_W-1:INTEG_W-1] == '1) begin
      integ_next = isum[INTEG_W-1:0];
    end else if (isum[PACC_W-1]) begin
      integ_next = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      integ_next = {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  // Divider operands: magnitude of the product; the derivative divides by dt*256.
  assign dmag = prod[MP_W-1] ? -prod : prod;
  assign den  = {dt_r, 8'd0};

  wfps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start && cmd.div_sel_d),
    .num   (dmag[DIV_W-1:0]),
    .den   (den),
    .quo   (quo_d),
    .rem   (rem_d),
    .done  (done_d)
  );

  // The integral term divides by a constant.
  wfps_cdiv u_cdiv (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start && !cmd.div_sel_d),
    .num    (dmag[DIV_W-1:0]),
    .quo    (quo_i),
    .rem_nz (rem_i_nz),
    .done   (done_i)
  );

  assign quo      = div_is_d ? quo_d : quo_i;
  assign rem_nz   = div_is_d ? (rem_d != '0) : rem_i_nz;
  assign div_done = done_d || done_i;

  // Floored signed quotient.
  always_comb begin
    qs = $signed(quo);
    if (div_neg) begin
      qs = -qs;
      if (rem_nz) begin
        qs = qs - 64'sd1;
      end
    end
  end

  // Steering: negate, round half up to 2^-12 rad, saturate; also the speed tier and saturated distance.
  always_comb begin
    tsum = 65'sd128 - (SUM_W+1)'(sum);
    tsh  = tsum >>> 8;
    if (tsh > 65'sd32767) begin
      steer_sat = 16'sd32767;
    end else if (tsh < -65'sd32768) begin
      steer_sat = -16'sd32768;
    end else begin
      steer_sat = tsh[15:0];
    end
    mag = steer_sat[15] ? -17'(steer_sat) : 17'(steer_sat);
    if (mag >= MAG_SLOW) begin
      speed = SPEED_SLOW;
    end else if (mag >= MAG_MID) begin
      speed = SPEED_MID;
    end else begin
      speed = SPEED_FAST;
    end
    if (proj > 20'sd32767) begin
      proj_sat = 16'sd32767;
    end else if (proj < -20'sd32768) begin
      proj_sat = -16'sd32768;
    end else begin
      proj_sat = proj[15:0];
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (cmd.load_in) begin
      a_r  <= scan.ray_a_valid ? scan.ray_a_range : FAR_RANGE;
      b_r  <= scan.ray_b_valid ? scan.ray_b_range : FAR_RANGE;
      dt_r <= scan.elapsed_us;
    end
    if (cmd.x_from_prod) begin
      x <= XY_W'(prod);
    end
    if (cmd.y_init) begin
      y <= XY_W'(prod) - XY_W'({b_r, 15'd0});
      z <= '0;
    end
    if (cmd.vec_step) begin
      if (!y[XY_W-1] && y != '0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end else if (y[XY_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end
    end
    if (cmd.rot_init) begin
      x <= KINV_Q30;
      y <= '0;
    end
    if (cmd.rot_step) begin
      if (!z[Z_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
    if (cmd.pacc_load) begin
      pacc <= PACC_W'(prod);
    end
    if (cmd.proj_load) begin
      proj <= PROJ_W'(psum >>> 30);
    end
    if (cmd.err_load) begin
      err <= ERR_W'($signed({1'b0, cfg.target_distance})) - ERR_W'(proj);
    end
    if (cmd.sum_load) begin
      sum <= SUM_W'(prod >>> 8);
    end else if (cmd.sum_add) begin
      sum <= sum + qs;
    end
    if (cmd.div_start) begin
      div_neg  <= prod[MP_W-1];
      div_is_d <= cmd.div_sel_d;
    end
    if (cmd.commit) begin
      result.wheel_angle        <= steer_sat;
      result.speed_mps          <= speed;
      result.projected_distance <= proj_sat;
    end
  end

  // Controller state carried from scan to scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= '0;
      integ    <= '0;
    end else begin
      if (cmd.integ_load) begin
        integ <= integ_next;
      end
      if (cmd.commit) begin
        last_err <= err;
      end
    end
  end

  assign sts.div_done = div_done;
  assign sts.dt_zero  = (dt_r == '0);

endmodule

// ===== src/wfps_ctrl.sv =====
module wfps_ctrl
  import wfps_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    scan_valid,
  output logic    scan_ready,
  output logic    steer_valid,
  input  logic    steer_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_M_ASIN = 20'h00002,
    S_M_ACOS = 20'h00004,
    S_VINIT  = 20'h00008,
    S_VEC    = 20'h00010,
    S_RINIT  = 20'h00020,
    S_ROT    = 20'h00040,
    S_M_BX   = 20'h00080,
    S_M_LY   = 20'h00100,
    S_PROJ   = 20'h00200,
    S_ERR    = 20'h00400,
    S_M_PE   = 20'h00800,
    S_M_GI   = 20'h01000,
    S_DIV_I  = 20'h02000,
    S_WAIT_I = 20'h04000,
    S_M_DIFF = 20'h08000,
    S_M_GD   = 20'h10000,
    S_DIV_D  = 20'h20000,
    S_WAIT_D = 20'h40000,
    S_FIN    = 20'h80000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             last_step;
  logic             out_free;

  assign last_step = (idx == IDX_W'(CORDIC_STEPS - 1));
  assign out_free  = !steer_valid || steer_ready;

  // Sequencer.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    cmd.idx    = idx;
    scan_ready = 1'b0;
    case (state)
      S_IDLE: begin
        scan_ready = 1'b1;
        if (scan_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_M_ASIN;
        end
      end
      S_M_ASIN: begin
        cmd.mul_op = MUL_A_SIN;
        state_next = S_M_ACOS;
      end
      S_M_ACOS: begin
        cmd.x_from_prod = 1'b1;
        cmd.mul_op      = MUL_A_COS;
        state_next      = S_VINIT;
      end
      S_VINIT: begin
        cmd.y_init = 1'b1;
        idx_next   = '0;
        state_next = S_VEC;
      end
      S_VEC: begin
        cmd.vec_step = 1'b1;
        idx_next     = idx + 1'b1;
        if (last_step) begin
          state_next = S_RINIT;
        end
      end
      S_RINIT: begin
        cmd.rot_init = 1'b1;
        idx_next     = '0;
        state_next   = S_ROT;
      end
      S_ROT: begin
        cmd.rot_step = 1'b1;
        idx_next     = idx + 1'b1;
        if (last_step) begin
          state_next = S_M_BX;
        end
      end
      S_M_BX: begin
        cmd.mul_op = MUL_B_X;
        state_next = S_M_LY;
      end
      S_M_LY: begin
        cmd.pacc_load = 1'b1;
        cmd.mul_op    = MUL_LA_Y;
        state_next    = S_PROJ;
      end
      S_PROJ: begin
        cmd.proj_load = 1'b1;
        cmd.mul_op    = MUL_LAST_DT;
        state_next    = S_ERR;
      end
      S_ERR: begin
        cmd.err_load   = 1'b1;
        cmd.integ_load = 1'b1;
        state_next     = S_M_PE;
      end
      S_M_PE: begin
        cmd.mul_op = MUL_P_E;
        state_next = S_M_GI;
      end
      S_M_GI: begin
        cmd.sum_load = 1'b1;
        cmd.mul_op   = MUL_I_INT;
        state_next   = S_DIV_I;
      end
      S_DIV_I: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT_I;
      end
      S_WAIT_I: begin
        if (sts.div_done) begin
          cmd.sum_add = 1'b1;
          state_next  = S_M_DIFF;
        end
      end
      S_M_DIFF: begin
        cmd.mul_op = MUL_DIFF_US;
        state_next = S_M_GD;
      end
      S_M_GD: begin
        cmd.mul_op = MUL_D_PROD;
        state_next = S_DIV_D;
      end
      S_DIV_D: begin
        cmd.div_sel_d = 1'b1;
        if (sts.dt_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_WAIT_D;
        end
      end
      S_WAIT_D: begin
        if (sts.div_done) begin
          cmd.sum_add = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, step counter and result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      steer_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.commit) begin
        steer_valid <= 1'b1;
      end else if (steer_ready) begin
        steer_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted scan starts the multiply sequence next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    scan_valid && scan_ready |=> state == S_M_ASIN)
    else $error("accepted scan did not start the sequence");

  // A result is only written into a free output slot.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!steer_valid || steer_ready))
    else $error("result overwrote an untaken transaction");

  // Quotients are folded in only when the divider has finished.
  a_add_on_done: assert property (@(posedge clk) disable iff (rst)
    cmd.sum_add |-> sts.div_done)
    else $error("sum updated without a finished division");
`endif

endmodule

// ===== src/wall_follow_pid_steering.sv =====
// Channel   Direction  Handshake                  Payload
// scan      in         scan_valid / scan_ready    scan_t (two ranges, flags, elapsed time)
// steer     out        steer_valid / steer_ready  steer_t (steering, speed, distance)
// apb       in         psel, penable, pwrite      paddr, pwdata, prdata (pready high)
//
// One scan runs two CORDIC passes of one step per cycle, the integral division in four
// digits of an estimate and a remainder phase each, and the 64-bit derivative division
// at two quotient bits per cycle, which is skipped at zero time.
// One scan is worked on at a time; the next is taken while a result waits.
// Reset is synchronous; it restores the register defaults and clears the PID state.
// A stalled output holds the finished result, and the block waits to write the next.
module wall_follow_pid_steering
  import wfps_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              scan_valid,
  output logic              scan_ready,
  input  scan_t             scan,
  output logic              steer_valid,
  input  logic              steer_ready,
  output steer_t            steer,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  wfps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wfps_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .scan_valid  (scan_valid),
    .scan_ready  (scan_ready),
    .steer_valid (steer_valid),
    .steer_ready (steer_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  wfps_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .scan   (scan),
    .cmd    (cmd),
    .sts    (sts),
    .result (steer)
  );

endmodule
